// File: hdl/bpfa_pkg.sv
package bpfa_pkg;

	localparam int NumPages  = 4096;
	localparam int MaxOrder  = 10;
	localparam int WordBits  = 32;
	localparam int NumWords  = NumPages / WordBits;
	localparam int PageW     = 12;
	localparam int WordIdxW  = 7;
	localparam int BitIdxW   = 5;
	localparam int CountW    = 13;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_KERNEL = 3'd1;
	localparam logic [2:0] ST_TOO_FEW   = 3'd2;
	localparam logic [2:0] ST_NO_RUN    = 3'd3;
	localparam logic [2:0] ST_PAGE_ZERO = 3'd4;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RESERVE = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [11:0] page_number;
		logic [3:0]  order;
		logic [12:0] range_count;
		logic        kernel_flag;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] start_page;
		logic [12:0] pages_in_use;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN_RD,
		S_SCAN,
		S_WR_RD,
		S_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             we;
		logic [WordIdxW-1:0] addr;
		logic [WordBits-1:0] wdata;
	} mem_ctl_t;

endpackage

// File: hdl/bpfa_bitmap_ram.sv
module bpfa_bitmap_ram
	import bpfa_pkg::*;
(
	input  logic                clk,
	input  mem_ctl_t            ctl,
	output logic [WordBits-1:0] rdata
);

	logic [WordBits-1:0] mem [NumWords];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.addr] <= ctl.wdata;
		end
		rdata <= mem[ctl.addr];
	end

endmodule

// File: hdl/bitmap_page_frame_allocator.sv
// One request at a time: busy rises after the transfer and done pulses for one cycle with the
// result; the receiver cannot stall. After reset a pass over all 128 bitmap words fills the
// bitmap with ones (busy high). Allocate scans page by page, each page read through a single
// registered bitmap word read port and then checked, stepping over a full word of used pages
// in one scan step, then writes the run page by page with a read and then a write. Free,
// reserve and release read and write each page touched in the same way. Result latency is
// data dependent: a rejected request goes straight to done, an allocate may scan the bitmap.
module bitmap_page_frame_allocator
	import bpfa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	state_t state_q, state_d;
	req_t   req_q;
	mem_ctl_t ctl;
	logic [WordBits-1:0] rdata;

	logic [CountW-1:0] used_q;
	logic [CountW-1:0] p_q;      // current page, may reach NumPages
	logic [CountW-1:0] left_q;   // pages left to write
	logic [CountW-1:0] run_q;
	logic [CountW-1:0] need_q;
	logic [PageW-1:0]  start_q;
	logic              set_q;
	logic [2:0]        status_q;
	logic [WordIdxW:0] clr_q;

	bpfa_bitmap_ram u_ram (.clk(clk), .ctl(ctl), .rdata(rdata));

	logic [CountW-1:0] n_ord;
	logic [CountW-1:0] free_cnt;
	logic              cur_used;
	logic [WordBits-1:0] bit_mask;
	logic              in_range;
	logic [2:0]        st_init;

	assign n_ord    = CountW'(1) << req.order;
	assign free_cnt = CountW'(NumPages) - used_q;
	assign cur_used = rdata[p_q[BitIdxW-1:0]];
	assign bit_mask = WordBits'(1) << p_q[BitIdxW-1:0];
	assign in_range = p_q < CountW'(NumPages);

	always_comb begin
		st_init = ST_OK;
		if (req.opcode == OP_ALLOC) begin
			if (!req.kernel_flag) st_init = ST_NO_KERNEL;
			else if (req.order > 4'(MaxOrder)) st_init = ST_NO_RUN;
			else if (free_cnt < n_ord) st_init = ST_TOO_FEW;
		end else if (req.opcode == OP_FREE) begin
			if (req.page_number == '0) st_init = ST_PAGE_ZERO;
			else if (req.order > 4'(MaxOrder)) st_init = ST_NO_RUN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			used_q  <= CountW'(NumPages);
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == S_WR && in_range && left_q != '0 && cur_used != set_q) begin
				used_q <= set_q ? used_q + 1'b1 : used_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (start) begin
				req_q    <= req;
				status_q <= st_init;
				start_q  <= '0;
				run_q    <= '0;
				need_q   <= n_ord;
				p_q      <= (req.opcode == OP_ALLOC) ? CountW'(1) : {1'b0, req.page_number};
				left_q   <= (req.opcode == OP_FREE) ? n_ord : req.range_count;
				set_q    <= req.opcode[1] ? !req.opcode[0] : 1'b0;
			end
			S_SCAN: begin
				if (!in_range) begin
					status_q <= ST_NO_RUN;
				end else if (p_q[BitIdxW-1:0] == '0 && run_q == '0 && rdata == '1) begin
					p_q <= p_q + CountW'(WordBits);
				end else if (cur_used) begin
					run_q <= '0;
					p_q   <= p_q + 1'b1;
				end else if (run_q + 1'b1 >= need_q) begin
					start_q <= PageW'(p_q + 1'b1 - need_q);
					p_q     <= p_q + 1'b1 - need_q;
					left_q  <= need_q;
					set_q   <= 1'b1;
				end else begin
					run_q <= run_q + 1'b1;
					p_q   <= p_q + 1'b1;
				end
			end
			S_WR: begin
				left_q <= left_q - 1'b1;
				p_q    <= p_q + 1'b1;
			end
			default: ;
		endcase
	end

	logic scan_hit;
	assign scan_hit = in_range && !(p_q[BitIdxW-1:0] == '0 && run_q == '0 && rdata == '1)
		&& !cur_used && (run_q + 1'b1 >= need_q);

	always_comb begin
		state_d    = state_q;
		ctl.we     = 1'b0;
		ctl.addr   = p_q[BitIdxW +: WordIdxW];
		ctl.wdata  = set_q ? (rdata | bit_mask) : (rdata & ~bit_mask);
		unique case (state_q)
			S_CLEAR: begin
				ctl.we    = 1'b1;
				ctl.addr  = clr_q[WordIdxW-1:0];
				ctl.wdata = '1;
				if (clr_q == (WordIdxW+1)'(NumWords - 1)) state_d = S_IDLE;
			end
			S_IDLE: if (start) state_d = S_DONE;
			S_SCAN_RD: state_d = S_SCAN;
			S_SCAN: begin
				if (!in_range) state_d = S_DONE;
				else if (scan_hit) state_d = S_WR_RD;
				else state_d = S_SCAN_RD;
			end
			S_WR_RD: state_d = S_WR;
			S_WR: begin
				if (left_q == '0 || !in_range) begin
					state_d = S_DONE;
				end else begin
					ctl.we  = 1'b1;
					state_d = S_WR_RD;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_IDLE && start) begin
			if (req.opcode == OP_ALLOC) begin
				if (req.kernel_flag && req.order <= 4'(MaxOrder) && free_cnt >= n_ord)
					state_d = S_SCAN_RD;
			end else if (req.opcode == OP_FREE) begin
				if (req.page_number != '0 && req.order <= 4'(MaxOrder)) state_d = S_WR_RD;
			end else begin
				state_d = S_WR_RD;
			end
		end
	end

	assign busy             = state_q != S_IDLE;
	assign done             = state_q == S_DONE;
	assign rsp.status       = status_q;
	assign rsp.start_page   = start_q;
	assign rsp.pages_in_use = used_q;

	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CountW'(NumPages)) else $error("used count overflow");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_start_nz: assert property (@(posedge clk) disable iff (!arst_n)
		done && req_q.opcode == OP_ALLOC && status_q == ST_OK |-> start_q != '0)
		else $error("allocation at page zero");
	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.we |-> busy) else $error("write while idle");

endmodule
